// ===== hdl/servo_packet_framer_checker_assert.svh =====
// assertion macros for the servo packet framer and reply checker
`ifndef SERVO_PACKET_FRAMER_CHECKER_ASSERT_SVH
`define SERVO_PACKET_FRAMER_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define SPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spf assertion failed");
// condition implies consequence in the next cycle
`define SPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spf assertion failed");
`else
`define SPF_ASSERT_IMP(lbl, ante, cons)
`define SPF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/spf_pkg.sv =====
// shared types and constants of the servo packet framer and reply checker
package spf_pkg;

  // request function codes
  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_PING  = 3'd2,
    FN_RESET = 3'd3,
    FN_RX    = 3'd4
  } spf_func_e;

  // packet framing bytes
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] INS_PING   = 8'h01;
  localparam logic [7:0] INS_READ   = 8'h02;
  localparam logic [7:0] INS_WRITE  = 8'h03;
  localparam logic [7:0] INS_RESET  = 8'h06;
  localparam logic [7:0] FACTORY_ID = 8'h01;

  // length field values
  localparam logic [7:0] LEN_WR1   = 8'd4;
  localparam logic [7:0] LEN_WR2   = 8'd5;
  localparam logic [7:0] LEN_READ  = 8'd4;
  localparam logic [7:0] LEN_SHORT = 8'd2;

  // index of the checksum byte in each packet
  localparam logic [3:0] LAST_WR1   = 4'd7;
  localparam logic [3:0] LAST_WR2   = 4'd8;
  localparam logic [3:0] LAST_READ  = 4'd7;
  localparam logic [3:0] LAST_SHORT = 4'd5;

  // reply lengths
  localparam logic [3:0] RPL_READ1 = 4'd7;
  localparam logic [3:0] RPL_READ2 = 4'd8;
  localparam logic [3:0] RPL_PING  = 4'd6;

  // reply byte positions
  localparam logic [3:0] POS_ID   = 4'd2;
  localparam logic [3:0] POS_VLO  = 4'd5;
  localparam logic [3:0] POS_VHI  = 4'd6;

  // request held in the job register
  typedef struct packed {
    spf_func_e   func;
    logic [7:0]  addr;
    logic        wr_two;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic        rd_two;
    logic [7:0]  rx_byte;
  } spf_job_t;

  // receiver arming from a finished command
  typedef struct packed {
    logic arm;
    logic disarm;
    logic ping;
    logic two;
  } spf_rx_ctl_t;

  // completed reply
  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic [7:0]  id;
    logic        ok;
  } spf_reply_t;

endpackage

// ===== hdl/spf_in_if.sv =====
// request channel of the servo packet framer and reply checker
interface spf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] reg_addr;
  logic [1:0] data_count;
  logic [7:0] data_low;
  logic [7:0] data_high;
  logic [1:0] rd_len;
  logic [7:0] rx_byte;

  modport source (
    output valid, func, reg_addr, data_count, data_low, data_high, rd_len, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, func, reg_addr, data_count, data_low, data_high, rd_len, rx_byte,
    output ready
  );
endinterface

// ===== hdl/spf_out_if.sv =====
// result channel of the servo packet framer and reply checker
interface spf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] reply_value;
  logic [7:0]  reply_id;
  logic        reply_ok;

  modport source (
    output valid, kind, tx_byte, last, reply_value, reply_id, reply_ok,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, last, reply_value, reply_id, reply_ok,
    output ready
  );
endinterface

// ===== hdl/spf_tx_frame.sv =====
// byte sequencer that walks one instruction packet and builds its checksum
module spf_tx_frame (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  spf_pkg::spf_job_t job_i,
  input  logic [7:0]       motor_id_i,
  output logic [7:0]       byte_o,
  output logic             last_o
);

  logic [3:0] idx_q, idx_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] last_idx;
  logic [7:0] len_byte;
  logic [7:0] ins_byte;
  logic [7:0] body_byte;

  // packet shape per function
  always_comb begin
    case (job_i.func)
      spf_pkg::FN_WRITE: begin
        last_idx = job_i.wr_two ? spf_pkg::LAST_WR2 : spf_pkg::LAST_WR1;
        len_byte = job_i.wr_two ? spf_pkg::LEN_WR2 : spf_pkg::LEN_WR1;
        ins_byte = spf_pkg::INS_WRITE;
      end
      spf_pkg::FN_READ: begin
        last_idx = spf_pkg::LAST_READ;
        len_byte = spf_pkg::LEN_READ;
        ins_byte = spf_pkg::INS_READ;
      end
      spf_pkg::FN_PING: begin
        last_idx = spf_pkg::LAST_SHORT;
        len_byte = spf_pkg::LEN_SHORT;
        ins_byte = spf_pkg::INS_PING;
      end
      spf_pkg::FN_RESET: begin
        last_idx = spf_pkg::LAST_SHORT;
        len_byte = spf_pkg::LEN_SHORT;
        ins_byte = spf_pkg::INS_RESET;
      end
      default: begin
        last_idx = spf_pkg::LAST_SHORT;
        len_byte = spf_pkg::LEN_SHORT;
        ins_byte = 8'h00;
      end
    endcase
  end

  // byte at the current position
  always_comb begin
    case (idx_q)
      4'd0, 4'd1: body_byte = spf_pkg::HDR_BYTE;
      4'd2:       body_byte = motor_id_i;
      4'd3:       body_byte = len_byte;
      4'd4:       body_byte = ins_byte;
      4'd5:       body_byte = job_i.addr;
      4'd6: begin
        if (job_i.func == spf_pkg::FN_WRITE) begin
          body_byte = job_i.d0;
        end else begin
          body_byte = job_i.rd_two ? 8'd2 : 8'd1;
        end
      end
      4'd7:       body_byte = job_i.d1;
      default:    body_byte = 8'h00;
    endcase
  end

  assign last_o = (idx_q == last_idx);
  assign byte_o = last_o ? ~sum_q : body_byte;

  // position and running sum over id..last parameter
  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    if (start_i) begin
      idx_d = '0;
      sum_d = '0;
    end else if (step_i) begin
      idx_d = idx_q + 4'd1;
      if (idx_q >= 4'd2) begin
        sum_d = sum_q + body_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

endmodule

// ===== hdl/spf_rx_chk.sv =====
// reply receiver: tracks reply position, sums bytes and reports on the final byte
module spf_rx_chk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spf_pkg::spf_rx_ctl_t ctl_i,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output spf_pkg::spf_reply_t  reply_o
);

  logic        armed_q;
  logic [3:0]  expected_q;
  logic [3:0]  index_q;
  logic [7:0]  sum_q;
  logic        ping_q;
  logic        two_q;
  logic [7:0]  id_q;
  logic [15:0] value_q;

  logic [7:0]  id_new;
  logic [15:0] value_new;
  logic        final_byte;
  logic        take;

  // field capture for the current byte
  always_comb begin
    id_new    = (index_q == spf_pkg::POS_ID) ? byte_i : id_q;
    value_new = value_q;
    if (index_q == spf_pkg::POS_VLO) begin
      value_new = {8'h00, byte_i};
    end else if (index_q == spf_pkg::POS_VHI && two_q && expected_q == spf_pkg::RPL_READ2) begin
      value_new = value_q | {byte_i, 8'h00};
    end
  end

  assign final_byte = ({1'b0, index_q} + 5'd1) >= {1'b0, expected_q};
  assign take       = step_i && armed_q;

  // reply result
  always_comb begin
    reply_o.valid = take && final_byte;
    reply_o.id    = id_new;
    reply_o.value = ping_q ? 16'h0000 : value_new;
    reply_o.ok    = ping_q ? 1'b1 : (~sum_q == byte_i);
  end

  // receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      expected_q <= '0;
      index_q    <= '0;
      sum_q      <= '0;
      ping_q     <= 1'b0;
      two_q      <= 1'b0;
      id_q       <= '0;
      value_q    <= '0;
    end else if (ctl_i.arm) begin
      armed_q    <= 1'b1;
      expected_q <= ctl_i.ping ? spf_pkg::RPL_PING :
                    (ctl_i.two ? spf_pkg::RPL_READ2 : spf_pkg::RPL_READ1);
      index_q    <= '0;
      sum_q      <= '0;
      ping_q     <= ctl_i.ping;
      two_q      <= ctl_i.two;
      id_q       <= '0;
      value_q    <= '0;
    end else if (ctl_i.disarm) begin
      armed_q <= 1'b0;
    end else if (take) begin
      id_q    <= id_new;
      value_q <= value_new;
      if (final_byte) begin
        armed_q <= 1'b0;
        index_q <= '0;
      end else begin
        if (index_q >= 4'd2) begin
          sum_q <= sum_q + byte_i;
        end
        index_q <= index_q + 4'd1;
      end
    end
  end

endmodule

// ===== hdl/servo_packet_framer_checker.sv =====
// Servo bus packet framer and reply checker. A command request (write, read,
// ping, reset) turns into one instruction packet, sent as one result byte per
// cycle unless res_o.ready holds it back: 6 bytes for ping or reset, 8 for a
// read, 8 or 9 for a write. A received-byte request gives a result only on the
// final byte of an awaited reply. Each request sits in a job register while
// its bytes go out through a single output register, so the rate is set by
// that one byte-wide result port; the next request is taken in the cycle the
// last byte of the current one is loaded, so packets follow each other without gaps.
`include "servo_packet_framer_checker_assert.svh"

module servo_packet_framer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  spf_in_if.sink     req_i,
  spf_out_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic                 job_valid_q;
  spf_pkg::spf_job_t    job_q;
  logic [7:0]           motor_id_q;

  logic                 adv;
  logic                 step;
  logic                 is_cmd;
  logic                 job_done;
  logic                 rst_cmd_done;
  logic                 accept;
  logic                 tx_load;
  logic [7:0]           tx_byte;
  logic                 tx_last;
  spf_pkg::spf_rx_ctl_t rx_ctl;
  spf_pkg::spf_reply_t  rx_res;

  logic        out_valid_q;
  logic        out_kind_q;
  logic [7:0]  out_tx_q;
  logic        out_last_q;
  logic [15:0] out_value_q;
  logic [7:0]  out_id_q;
  logic        out_ok_q;

  // handshake and job progress
  assign adv      = !out_valid_q || res_o.ready;
  assign step     = job_valid_q && adv;
  assign is_cmd   = job_q.func inside {spf_pkg::FN_WRITE, spf_pkg::FN_READ,
                                       spf_pkg::FN_PING, spf_pkg::FN_RESET};
  assign job_done = step && (is_cmd ? tx_last : 1'b1);
  assign rst_cmd_done = job_done && (job_q.func == spf_pkg::FN_RESET);
  assign req_i.ready = !job_valid_q || job_done;
  assign accept   = req_i.valid && req_i.ready;
  assign tx_load  = step && is_cmd;

  // job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (accept) begin
      job_valid_q <= 1'b1;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.func    <= spf_pkg::spf_func_e'(req_i.func);
      job_q.addr    <= req_i.reg_addr;
      job_q.wr_two  <= req_i.data_count[1];
      job_q.d0      <= req_i.data_low;
      job_q.d1      <= req_i.data_high;
      job_q.rd_two  <= (req_i.rd_len != 2'd1);
      job_q.rx_byte <= req_i.rx_byte;
    end
  end

  // motor id register, factory id after a reset command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q <= spf_pkg::FACTORY_ID;
    end else if (rst_cmd_done) begin
      motor_id_q <= spf_pkg::FACTORY_ID;
    end else if (cfg_we_i) begin
      motor_id_q <= cfg_wdata_i;
    end
  end

  spf_tx_frame u_tx_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .step_i     (tx_load),
    .job_i      (job_q),
    .motor_id_i (motor_id_q),
    .byte_o     (tx_byte),
    .last_o     (tx_last)
  );

  // receiver arming when a command finishes
  always_comb begin
    rx_ctl.arm    = job_done && (job_q.func == spf_pkg::FN_READ ||
                                 job_q.func == spf_pkg::FN_PING);
    rx_ctl.disarm = job_done && (job_q.func == spf_pkg::FN_WRITE ||
                                 job_q.func == spf_pkg::FN_RESET);
    rx_ctl.ping   = (job_q.func == spf_pkg::FN_PING);
    rx_ctl.two    = job_q.rd_two;
  end

  spf_rx_chk u_rx_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rx_ctl),
    .step_i  (step && job_q.func == spf_pkg::FN_RX),
    .byte_i  (job_q.rx_byte),
    .reply_o (rx_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tx_load || rx_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (tx_load) begin
        out_kind_q  <= 1'b0;
        out_tx_q    <= tx_byte;
        out_last_q  <= tx_last;
        out_value_q <= '0;
        out_id_q    <= '0;
        out_ok_q    <= 1'b0;
      end else if (rx_res.valid) begin
        out_kind_q  <= 1'b1;
        out_tx_q    <= '0;
        out_last_q  <= 1'b1;
        out_value_q <= rx_res.value;
        out_id_q    <= rx_res.id;
        out_ok_q    <= rx_res.ok;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.tx_byte     = out_tx_q;
  assign res_o.last        = out_last_q;
  assign res_o.reply_value = out_value_q;
  assign res_o.reply_id    = out_id_q;
  assign res_o.reply_ok    = out_ok_q;

  // checks
  `SPF_ASSERT_NXT(a_reset_id, rst_cmd_done && !cfg_we_i, motor_id_q == spf_pkg::FACTORY_ID)
  `SPF_ASSERT_NXT(a_tx_result, tx_load, out_valid_q && !out_kind_q)
  `SPF_ASSERT_IMP(a_reply_from_rx, rx_res.valid, step && job_q.func == spf_pkg::FN_RX)
  `SPF_ASSERT_IMP(a_accept_free, accept && job_valid_q, job_done)

endmodule
